@@ src/lsr_pkg.sv @@
// Shared types and constants for the line segment rasterizer.
// Depends on nothing; used by lsr_cfg_regs and line_segment_rasterizer.
package lsr_pkg;

    localparam int FRAME_W = 12;
    localparam int COLOR_W = 24;
    localparam int PIX_W   = 11;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 2;

    // Largest column or row the pixel outputs can carry.
    localparam int PIX_MAX = 2047;

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic [COLOR_W-1:0] PIXEL_COLOR_RST  = 24'hFF_FFFF;

    // Register indexes; the byte address is four times the index.
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_PIXEL_COLOR  = 2'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_width;
        logic [FRAME_W-1:0] frame_height;
        logic [COLOR_W-1:0] pixel_color;
    } cfg_t;

endpackage

@@ src/lsr_cfg_regs.sv @@
// APB-style configuration registers of the line segment rasterizer.
// Depends on lsr_pkg for register indexes, reset values and cfg_t.
module lsr_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsr_pkg::ADDR_W-1:0]  paddr,
    input  logic [lsr_pkg::DATA_W-1:0]  pwdata,
    output logic [lsr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output lsr_pkg::cfg_t               cfg
);

    lsr_pkg::cfg_t              cfg_reg;
    logic [lsr_pkg::IDX_W-1:0]  reg_idx;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[lsr_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= lsr_pkg::FRAME_WIDTH_RST;
            cfg_reg.frame_height <= lsr_pkg::FRAME_HEIGHT_RST;
            cfg_reg.pixel_color  <= lsr_pkg::PIXEL_COLOR_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                lsr_pkg::REG_FRAME_WIDTH:
                begin
                    cfg_reg.frame_width <= pwdata[lsr_pkg::FRAME_W-1:0];
                end
                lsr_pkg::REG_FRAME_HEIGHT:
                begin
                    cfg_reg.frame_height <= pwdata[lsr_pkg::FRAME_W-1:0];
                end
                lsr_pkg::REG_PIXEL_COLOR:
                begin
                    cfg_reg.pixel_color <= pwdata[lsr_pkg::COLOR_W-1:0];
                end
                default:
                begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            lsr_pkg::REG_FRAME_WIDTH:
                prdata = {{(lsr_pkg::DATA_W-lsr_pkg::FRAME_W){1'b0}}, cfg_reg.frame_width};
            lsr_pkg::REG_FRAME_HEIGHT:
                prdata = {{(lsr_pkg::DATA_W-lsr_pkg::FRAME_W){1'b0}}, cfg_reg.frame_height};
            lsr_pkg::REG_PIXEL_COLOR:
                prdata = {{(lsr_pkg::DATA_W-lsr_pkg::COLOR_W){1'b0}}, cfg_reg.pixel_color};
            default:
                prdata = '0;
        endcase
    end

endmodule

@@ src/line_segment_rasterizer.sv @@
// First-octant line rasterizer: a load request stores a segment, and each step request
// walks one column and yields the pixel on it, or nothing when it is off the frame or no
// segment is active. The error accumulator add, compare and subtract are combinational,
// so a request is accepted in every cycle while the output register is empty or being
// drained, and its pixel appears on the outputs in the cycle after it is accepted.
// Depends on lsr_pkg and lsr_cfg_regs.
module line_segment_rasterizer
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lsr_pkg::ADDR_W-1:0]       paddr,
    input  logic [lsr_pkg::DATA_W-1:0]       pwdata,
    output logic [lsr_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             action,
    input  logic signed [COORD_BITS-1:0]     start_x,
    input  logic signed [COORD_BITS-1:0]     start_y,
    input  logic signed [COORD_BITS-1:0]     end_x,
    input  logic signed [COORD_BITS-1:0]     end_y,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [lsr_pkg::PIX_W-1:0]        pixel_x,
    output logic [lsr_pkg::PIX_W-1:0]        pixel_y,
    output logic [lsr_pkg::COLOR_W-1:0]      color_out,
    output logic                             last_pixel
);

    localparam int CW    = COORD_BITS;
    localparam int CMP_W = ((CW > lsr_pkg::FRAME_W) ? CW : lsr_pkg::FRAME_W) + 1;

    lsr_pkg::cfg_t cfg;

    lsr_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic signed [CW-1:0]       cur_x_reg, cur_x_next;
    logic signed [CW-1:0]       cur_y_reg, cur_y_next;
    logic signed [CW-1:0]       stop_x_reg, stop_x_next;
    logic [CW-1:0]              delta_x_reg, delta_x_next;
    logic [CW-1:0]              delta_y_reg, delta_y_next;
    logic [CW-1:0]              error_acc_reg, error_acc_next;
    logic                       active_reg, active_next;

    logic                       out_valid_reg, out_valid_next;
    logic [lsr_pkg::PIX_W-1:0]  pixel_x_reg;
    logic [lsr_pkg::PIX_W-1:0]  pixel_y_reg;
    logic [lsr_pkg::COLOR_W-1:0] color_out_reg;
    logic                       last_pixel_reg;

    logic                       in_fire;
    logic                       load_fire;
    logic                       step_fire;
    logic signed [CW:0]         span_x;
    logic signed [CW:0]         span_y;
    logic                       octant_ok;
    logic                       last_col;
    logic [CMP_W-1:0]           x_ext;
    logic [CMP_W-1:0]           y_ext;
    logic                       in_frame;
    logic                       emit;
    logic [CW:0]                err_sum;
    logic                       err_wrap;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign load_fire = in_fire && (action == lsr_pkg::ACT_LOAD);
    assign step_fire = in_fire && (action == lsr_pkg::ACT_STEP);

    assign span_x    = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
    assign span_y    = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
    assign octant_ok = (end_x > start_x) && (end_y > start_y) && (span_x > span_y);

    assign last_col  = (cur_x_reg >= stop_x_reg);

    // Coordinates are only looked at unsigned once the sign bit is known clear.
    assign x_ext    = {{(CMP_W-CW){1'b0}}, cur_x_reg};
    assign y_ext    = {{(CMP_W-CW){1'b0}}, cur_y_reg};
    assign in_frame = !cur_x_reg[CW-1] && !cur_y_reg[CW-1]
                   && (x_ext < {{(CMP_W-lsr_pkg::FRAME_W){1'b0}}, cfg.frame_width})
                   && (y_ext < {{(CMP_W-lsr_pkg::FRAME_W){1'b0}}, cfg.frame_height})
                   && (x_ext <= CMP_W'(lsr_pkg::PIX_MAX))
                   && (y_ext <= CMP_W'(lsr_pkg::PIX_MAX));
    assign emit     = step_fire && active_reg && in_frame;

    // error_acc stays below delta_x, so one conditional subtract restores it.
    assign err_sum  = {1'b0, error_acc_reg} + {1'b0, delta_y_reg};
    assign err_wrap = (err_sum >= {1'b0, delta_x_reg});

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        stop_x_next    = stop_x_reg;
        delta_x_next   = delta_x_reg;
        delta_y_next   = delta_y_reg;
        error_acc_next = error_acc_reg;
        active_next    = active_reg;

        if (load_fire)
        begin
            active_next = octant_ok;
            if (octant_ok)
            begin
                cur_x_next     = start_x;
                cur_y_next     = start_y;
                stop_x_next    = end_x;
                delta_x_next   = span_x[CW-1:0];
                delta_y_next   = span_y[CW-1:0];
                error_acc_next = '0;
            end
        end
        else if (step_fire && active_reg)
        begin
            if (last_col)
            begin
                active_next = 1'b0;
            end
            else
            begin
                cur_x_next = cur_x_reg + CW'(1);
                if (err_wrap)
                begin
                    error_acc_next = CW'(err_sum - {1'b0, delta_x_reg});
                    cur_y_next     = cur_y_reg + CW'(1);
                end
                else
                begin
                    error_acc_next = err_sum[CW-1:0];
                end
            end
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            stop_x_reg    <= '0;
            delta_x_reg   <= '0;
            delta_y_reg   <= '0;
            error_acc_reg <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            stop_x_reg    <= stop_x_next;
            delta_x_reg   <= delta_x_next;
            delta_y_reg   <= delta_y_next;
            error_acc_reg <= error_acc_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_x_reg    <= x_ext[lsr_pkg::PIX_W-1:0];
            pixel_y_reg    <= y_ext[lsr_pkg::PIX_W-1:0];
            color_out_reg  <= cfg.pixel_color;
            last_pixel_reg <= last_col;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign color_out  = color_out_reg;
    assign last_pixel = last_pixel_reg;

    // While a segment is active, the accumulator holds the remainder of the slope fraction.
    a_err_below_dx: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (error_acc_reg < delta_x_reg))
        else $error("error accumulator reached delta_x");

    // The walk never passes the end column.
    a_x_not_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (cur_x_reg <= stop_x_reg))
        else $error("current column beyond segment end");

    // A fresh segment starts with a clean accumulator.
    a_load_clears_err: assert property (@(posedge clk) disable iff (!rst_n)
        (load_fire && octant_ok) |=> (active_reg && error_acc_reg == '0))
        else $error("load did not start a clean segment");

    // A load never produces a pixel.
    a_load_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (load_fire && !(out_valid_reg && !out_ready)) |=> !out_valid_reg)
        else $error("pixel produced by a load request");

endmodule
